FILE: rtl/bitmap_next_fit_block_allocator_assert.svh
// Assertion macros shared by the allocator RTL.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef BITMAP_NEXT_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_NEXT_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BNF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, disabled while reset is held.
`define BNF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

FILE: rtl/bnf_pkg.sv
// Shared types and constants of the bitmap next-fit block allocator.
// Depends on nothing; every other RTL file but the assertion header uses it by scoped names.
package bnf_pkg;

  localparam int DATA_W   = 32;
  localparam int ROOM_W   = 16;
  localparam int ROW_BITS = 64;
  localparam int ROW_LOG2 = 6;
  localparam int HI_W     = ROW_LOG2 + 1;

  localparam logic [ROOM_W-1:0] ROOM_RST = 16'd4096;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [0:0] CFG_BASE = 1'b0;
  localparam logic [0:0] CFG_ROOM = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMEM   = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_GROW,
    S_GCHK,
    S_GREAD,
    S_GSET,
    S_FCALC,
    S_FCHK,
    S_FCLR,
    S_RESP
  } state_t;

  typedef struct packed {
    logic                found;
    logic [ROW_BITS-1:0] onehot;
    logic [ROW_LOG2-1:0] pos;
  } scan_res_t;

endpackage

FILE: rtl/bnf_if.sv
// Valid/ready channel interfaces for allocator requests and results.
// Depends on bnf_pkg for the field widths.
interface bnf_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [bnf_pkg::DATA_W-1:0]  free_address;

  modport source (output valid, action, free_address, input ready);
  modport sink (input valid, action, free_address, output ready);
endinterface

interface bnf_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [bnf_pkg::DATA_W-1:0]  block_address;

  modport source (output valid, status, block_address, input ready);
  modport sink (input valid, status, block_address, output ready);
endinterface

FILE: rtl/bnf_bitmap.sv
// Used/free bitmap store: one 64-bit row per entry, one write and one read port.
// Read data is registered. Depends on bnf_pkg for the row width.
module bnf_bitmap #(
  parameter int ROWS = 64,
  parameter int RW   = 6
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [RW-1:0]                wr_addr,
  input  logic [bnf_pkg::ROW_BITS-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [RW-1:0]                rd_addr,
  output logic [bnf_pkg::ROW_BITS-1:0] rd_data
);

  logic [bnf_pkg::ROW_BITS-1:0] mem [ROWS];
  logic [bnf_pkg::ROW_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/bnf_scan.sv
// Row scanner: finds the lowest free bit of one bitmap row inside a window.
// Depends on bnf_pkg for the row width and the result struct.
module bnf_scan (
  input  logic [bnf_pkg::ROW_BITS-1:0] row_data,
  input  logic [bnf_pkg::ROW_LOG2-1:0] lo,
  input  logic [bnf_pkg::HI_W-1:0]     hi,
  output bnf_pkg::scan_res_t           res
);

  logic [bnf_pkg::ROW_BITS-1:0] avail;
  logic [bnf_pkg::ROW_BITS-1:0] lowest;
  logic [bnf_pkg::ROW_LOG2-1:0] pos;
  logic [bnf_pkg::ROW_LOG2-1:0] idx;

  always_comb begin
    for (int i = 0; i < bnf_pkg::ROW_BITS; i++) begin
      avail[i] = !row_data[i] && (bnf_pkg::HI_W'(i) >= {1'b0, lo})
                 && (bnf_pkg::HI_W'(i) < hi);
    end
    lowest = avail & (~avail + 1'b1);
    pos = '0;
    for (int i = 0; i < bnf_pkg::ROW_BITS; i++) begin
      idx = bnf_pkg::ROW_LOG2'(i);
      for (int k = 0; k < bnf_pkg::ROW_LOG2; k++) begin
        pos[k] = pos[k] | (lowest[i] & idx[k]);
      end
    end
    res.found  = |avail;
    res.onehot = lowest;
    res.pos    = pos;
  end

endmodule

FILE: rtl/bitmap_next_fit_block_allocator.sv
// Fixed-size block allocator over a used/free bitmap with a next-fit pointer. After reset
// the bitmap is cleared one 64-bit row per cycle, all ceil(MAX_BLOCKS/64) rows (64 at the
// defaults), before the first word is taken. An allocation scans one bitmap row per cycle
// from the pointer's row through the active region (up to 16 rows at 1024 active blocks);
// a scan that runs off the end grows the region and grants its first new block, or reports
// full if the map is already at its maximum, or no memory if the heap room is used up. A
// free computes the block index, checks it, clears its bit if in the store and responds.
// The result sits in an output register, and the next word can be accepted while it waits.
// Depends on bnf_pkg, bnf_if, bnf_bitmap, bnf_scan and the assertion macro header.
`include "bitmap_next_fit_block_allocator_assert.svh"

module bitmap_next_fit_block_allocator #(
  parameter int MAX_BLOCKS      = 4096,
  parameter int BLOCK_SIZE_LOG2 = 12,
  parameter int GROW_STEP       = 64,
  parameter int INIT_BLOCKS     = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bnf_in_if.sink                      in_word,
  bnf_out_if.source                   out_word,
  input  logic                        cfg_wr_en,
  input  logic [0:0]                  cfg_index,
  input  logic [bnf_pkg::DATA_W-1:0]  cfg_data
);

  localparam int PW   = $clog2(MAX_BLOCKS);
  localparam int CW   = $clog2(MAX_BLOCKS + 1);
  localparam int ROWS = (MAX_BLOCKS + bnf_pkg::ROW_BITS - 1) / bnf_pkg::ROW_BITS;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FW   = bnf_pkg::DATA_W - BLOCK_SIZE_LOG2;
  localparam int EW   = bnf_pkg::DATA_W + 1;
  localparam int RST_ACTIVE = (INIT_BLOCKS > MAX_BLOCKS) ? MAX_BLOCKS : INIT_BLOCKS;

  localparam logic [bnf_pkg::ROW_BITS-1:0] ONE_BIT = bnf_pkg::ROW_BITS'(1);

  bnf_pkg::state_t  state_r, state_nxt;
  logic [RW-1:0]    clr_r, clr_nxt;
  logic [PW-1:0]    next_r, next_nxt;
  logic [CW-1:0]    active_r, active_nxt;
  logic [bnf_pkg::ROOM_W-1:0] grown_r, grown_nxt;
  logic [bnf_pkg::DATA_W-1:0] base_r;
  logic [bnf_pkg::ROOM_W-1:0] room_r;
  logic [bnf_pkg::DATA_W-1:0] faddr_r, faddr_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [PW-1:0]    blk_r, blk_nxt;
  logic [FW-1:0]    fblk_r, fblk_nxt;
  bnf_pkg::status_t stat_r, stat_nxt;
  logic             grant_r, grant_nxt;
  logic             out_valid_r, out_valid_nxt;
  bnf_pkg::status_t out_status_r, out_status_nxt;
  logic [bnf_pkg::DATA_W-1:0] out_addr_r, out_addr_nxt;

  logic                         wr_en;
  logic [RW-1:0]                wr_addr;
  logic [bnf_pkg::ROW_BITS-1:0] wr_data;
  logic                         rd_en;
  logic [RW-1:0]                rd_addr;
  logic [bnf_pkg::ROW_BITS-1:0] rd_data;

  logic [EW-1:0]                row_base;
  logic [EW-1:0]                rem;
  logic [bnf_pkg::ROW_LOG2-1:0] scan_lo;
  logic [bnf_pkg::HI_W-1:0]     scan_hi;
  logic                         scan_last;
  bnf_pkg::scan_res_t           scan_res;
  logic [EW-1:0]                grow_sum;
  logic [bnf_pkg::ROOM_W:0]     grown_sum;
  logic [EW-1:0]                blk_inc;
  logic                         in_store;

  function automatic logic [RW-1:0] row_of(input logic [PW-1:0] b);
    return RW'(b >> bnf_pkg::ROW_LOG2);
  endfunction

  bnf_bitmap #(
    .ROWS (ROWS),
    .RW   (RW)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bnf_scan u_scan (
    .row_data (rd_data),
    .lo       (scan_lo),
    .hi       (scan_hi),
    .res      (scan_res)
  );

  always_comb begin
    row_base  = EW'(row_r) << bnf_pkg::ROW_LOG2;
    rem       = EW'(active_r) - row_base;
    scan_hi   = (rem >= EW'(bnf_pkg::ROW_BITS)) ? bnf_pkg::HI_W'(bnf_pkg::ROW_BITS)
                                                : bnf_pkg::HI_W'(rem);
    scan_last = (rem <= EW'(bnf_pkg::ROW_BITS));
    scan_lo   = (row_r == row_of(next_r)) ? next_r[bnf_pkg::ROW_LOG2-1:0] : '0;
    grow_sum  = EW'(active_r) + EW'(GROW_STEP);
    grown_sum = (bnf_pkg::ROOM_W + 1)'(grown_r) + (bnf_pkg::ROOM_W + 1)'(GROW_STEP);
    blk_inc   = EW'(blk_r) + EW'(1);
    in_store  = (EW'(fblk_r) < EW'(MAX_BLOCKS));
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    next_nxt       = next_r;
    active_nxt     = active_r;
    grown_nxt      = grown_r;
    faddr_nxt      = faddr_r;
    row_nxt        = row_r;
    blk_nxt        = blk_r;
    fblk_nxt       = fblk_r;
    stat_nxt       = stat_r;
    grant_nxt      = grant_r;
    out_valid_nxt  = out_valid_r && !out_word.ready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    wr_en          = 1'b0;
    wr_addr        = row_of(blk_r);
    wr_data        = rd_data;
    rd_en          = 1'b0;
    rd_addr        = row_of(blk_r);
    in_word.ready  = 1'b0;

    case (state_r)
      bnf_pkg::S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == RW'(ROWS - 1)) begin
          state_nxt = bnf_pkg::S_IDLE;
        end
      end
      bnf_pkg::S_IDLE: begin
        in_word.ready = 1'b1;
        rd_en         = 1'b1;
        rd_addr       = row_of(next_r);
        if (in_word.valid) begin
          grant_nxt = 1'b0;
          if (in_word.action == bnf_pkg::ACT_ALLOC) begin
            row_nxt   = row_of(next_r);
            state_nxt = bnf_pkg::S_SCAN;
          end else begin
            faddr_nxt = in_word.free_address;
            state_nxt = bnf_pkg::S_FCALC;
          end
        end
      end
      bnf_pkg::S_SCAN: begin
        if (scan_res.found) begin
          wr_en     = 1'b1;
          wr_addr   = row_r;
          wr_data   = rd_data | scan_res.onehot;
          blk_nxt   = PW'({row_r, scan_res.pos});
          grant_nxt = 1'b1;
          stat_nxt  = bnf_pkg::ST_OK;
          state_nxt = bnf_pkg::S_RESP;
        end else if (scan_last) begin
          state_nxt = bnf_pkg::S_GROW;
        end else begin
          rd_en   = 1'b1;
          rd_addr = row_r + 1'b1;
          row_nxt = row_r + 1'b1;
        end
      end
      bnf_pkg::S_GROW: begin
        if (active_r == CW'(MAX_BLOCKS)) begin
          stat_nxt  = bnf_pkg::ST_FULL;
          state_nxt = bnf_pkg::S_RESP;
        end else begin
          blk_nxt    = PW'(active_r);
          active_nxt = (grow_sum > EW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(grow_sum);
          grown_nxt  = grown_sum[bnf_pkg::ROOM_W] ? '1 : grown_sum[bnf_pkg::ROOM_W-1:0];
          state_nxt  = bnf_pkg::S_GCHK;
        end
      end
      bnf_pkg::S_GCHK: begin
        if (grown_r >= room_r) begin
          stat_nxt  = bnf_pkg::ST_NOMEM;
          state_nxt = bnf_pkg::S_RESP;
        end else begin
          state_nxt = bnf_pkg::S_GREAD;
        end
      end
      bnf_pkg::S_GREAD: begin
        rd_en     = 1'b1;
        state_nxt = bnf_pkg::S_GSET;
      end
      bnf_pkg::S_GSET: begin
        wr_en     = 1'b1;
        wr_data   = rd_data | (ONE_BIT << blk_r[bnf_pkg::ROW_LOG2-1:0]);
        grant_nxt = 1'b1;
        stat_nxt  = bnf_pkg::ST_OK;
        state_nxt = bnf_pkg::S_RESP;
      end
      bnf_pkg::S_FCALC: begin
        fblk_nxt  = FW'((base_r - faddr_r) >> BLOCK_SIZE_LOG2);
        state_nxt = bnf_pkg::S_FCHK;
      end
      bnf_pkg::S_FCHK: begin
        if ((EW'(fblk_r) > EW'(active_r)) || !in_store) begin
          stat_nxt = bnf_pkg::ST_BADFREE;
        end else begin
          stat_nxt = bnf_pkg::ST_OK;
        end
        if (in_store) begin
          blk_nxt   = PW'(fblk_r);
          rd_en     = 1'b1;
          rd_addr   = RW'(fblk_r >> bnf_pkg::ROW_LOG2);
          state_nxt = bnf_pkg::S_FCLR;
        end else begin
          state_nxt = bnf_pkg::S_RESP;
        end
      end
      bnf_pkg::S_FCLR: begin
        wr_en     = 1'b1;
        wr_data   = rd_data & ~(ONE_BIT << blk_r[bnf_pkg::ROW_LOG2-1:0]);
        state_nxt = bnf_pkg::S_RESP;
      end
      bnf_pkg::S_RESP: begin
        if (!out_valid_r || out_word.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_addr_nxt   = grant_r
                           ? base_r - (bnf_pkg::DATA_W'(blk_r) << BLOCK_SIZE_LOG2) : '0;
          if (grant_r) begin
            next_nxt = (blk_inc >= EW'(active_r)) ? '0 : PW'(blk_inc);
          end
          state_nxt = bnf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bnf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bnf_pkg::S_CLEAR;
      clr_r       <= '0;
      next_r      <= '0;
      active_r    <= CW'(RST_ACTIVE);
      grown_r     <= '0;
      grant_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      next_r      <= next_nxt;
      active_r    <= active_nxt;
      grown_r     <= grown_nxt;
      grant_r     <= grant_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    faddr_r      <= faddr_nxt;
    row_r        <= row_nxt;
    blk_r        <= blk_nxt;
    fblk_r       <= fblk_nxt;
    stat_r       <= stat_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      room_r <= bnf_pkg::ROOM_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == bnf_pkg::CFG_BASE) begin
        base_r <= cfg_data;
      end else begin
        room_r <= cfg_data[bnf_pkg::ROOM_W-1:0];
      end
    end
  end

  assign out_word.valid         = out_valid_r;
  assign out_word.status        = out_status_r;
  assign out_word.block_address = out_addr_r;

  `BNF_ASSERT_IMP(a_next_in_range, clk, rst_n, 1'b1, EW'(next_r) < EW'(active_r))
  `BNF_ASSERT_IMP(a_fail_no_addr, clk, rst_n, out_valid_r && (out_status_r != bnf_pkg::ST_OK), out_addr_r == '0)
  `BNF_ASSERT_NXT(a_accept_busy, clk, rst_n, in_word.valid && in_word.ready, state_r != bnf_pkg::S_IDLE)
  `BNF_ASSERT_IMP(a_grow_moves_active, clk, rst_n, grown_r != $past(grown_r), active_r != $past(active_r))

endmodule
